// ----- sv/swedf_pkg.sv -----
`timescale 1ns / 1ps

package swedf_pkg;

  localparam int DEF_QUEUE_DEPTH   = 256;
  localparam int DEF_POSITION_BITS = 24;

  localparam int LEN_BITS   = 16;
  localparam int SIZE_BITS  = 16;
  localparam int WIN_BITS   = 16;
  localparam int SUM_BITS   = 24;
  localparam int TOTAL_BITS = 32;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Register index, taken from byte address bit 2.
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_MAX_SUM     = 1'b1;

  localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RESET = 16'd100;
  localparam logic [SUM_BITS-1:0] MAX_SUM_RESET     = 24'd5;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_FINISH  = 1'b1;

  typedef struct packed {
    logic latch;
    logic rd_en;
    logic rd_next;
    logic pop;
    logic cap_head;
    logic push;
    logic drop;
    logic decide;
    logic finish;
    logic load_out;
  } swedf_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic occ_one;
    logic full;
    logic keep;
    logic res_pending;
    logic out_free;
  } swedf_sts_t;

endpackage

// ----- sv/swedf_if.sv -----
`timescale 1ns / 1ps

interface swedf_in_if #(
  parameter int POSITION_BITS = swedf_pkg::DEF_POSITION_BITS
);
  import swedf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [POSITION_BITS-1:0] position;
  logic [LEN_BITS-1:0]      ref_length;
  logic [SIZE_BITS-1:0]     event_size;

  modport src (output valid, command, position, ref_length, event_size, input ready);
  modport snk (input valid, command, position, ref_length, event_size, output ready);
endinterface

interface swedf_out_if #(
  parameter int POSITION_BITS = swedf_pkg::DEF_POSITION_BITS
);
  logic                   valid;
  logic                   ready;
  logic [POSITION_BITS-1:0] span_begin;
  logic [POSITION_BITS:0]   span_end;
  logic                   dropped;

  modport src (output valid, span_begin, span_end, dropped, input ready);
  modport snk (input valid, span_begin, span_end, dropped, output ready);
endinterface

// ----- sv/sliding_window_event_density_flagger_core.sv -----
`timescale 1ns / 1ps
// Finish transaction: FINISH closes any open span, then OUT offers it and returns to IDLE.
// Event transaction: an eviction pass (EV_RD, EV_CMP), APPEND, a second eviction pass, DECIDE,
// then OUT (APPEND drops the event on a full queue); the head check reads one entry per cycle.
// A new result waits in the datapath while the previous one is untaken, stalling the input.
// Reset (synchronous, rst_n low) empties the queue and span state; no clearing pass.
module sliding_window_event_density_flagger_core #(
  parameter int QUEUE_DEPTH   = swedf_pkg::DEF_QUEUE_DEPTH,
  parameter int POSITION_BITS = swedf_pkg::DEF_POSITION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  swedf_in_if.snk                             in_ch,
  swedf_out_if.src                            out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [swedf_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [swedf_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [swedf_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import swedf_pkg::*;

  swedf_cmd_t           cmd;
  swedf_sts_t           sts;
  logic [WIN_BITS-1:0]  window_size;
  logic [SUM_BITS-1:0]  max_sum;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  swedf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .window_size (window_size),
    .max_sum     (max_sum)
  );

  swedf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  swedf_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_position    (in_ch.position),
    .in_ref_length  (in_ch.ref_length),
    .in_event_size  (in_ch.event_size),
    .window_size    (window_size),
    .max_sum        (max_sum),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_span_begin (out_ch.span_begin),
    .out_span_end   (out_ch.span_end),
    .out_dropped    (out_ch.dropped)
  );

endmodule

// ----- sv/swedf_cfg.sv -----
`timescale 1ns / 1ps

module swedf_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swedf_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [swedf_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [swedf_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                 pready,
  output logic [swedf_pkg::WIN_BITS-1:0]       window_size,
  output logic [swedf_pkg::SUM_BITS-1:0]       max_sum
);
  import swedf_pkg::*;

  logic [WIN_BITS-1:0] window_size_r, window_size_nxt;
  logic [SUM_BITS-1:0] max_sum_r, max_sum_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    window_size_nxt = window_size_r;
    max_sum_nxt     = max_sum_r;
    if (wr_en) begin
      case (paddr[2])
        REG_WINDOW_SIZE: window_size_nxt = pwdata[WIN_BITS-1:0];
        REG_MAX_SUM:     max_sum_nxt     = pwdata[SUM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
      max_sum_r     <= MAX_SUM_RESET;
    end else begin
      window_size_r <= window_size_nxt;
      max_sum_r     <= max_sum_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_SIZE: prdata = CFG_DATA_BITS'(window_size_r);
      REG_MAX_SUM:     prdata = CFG_DATA_BITS'(max_sum_r);
      default:         prdata = '0;
    endcase
  end

  assign window_size = window_size_r;
  assign max_sum     = max_sum_r;

endmodule

// ----- sv/swedf_ctrl.sv -----
`timescale 1ns / 1ps

module swedf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_command,
  output logic                    in_ready,
  input  swedf_pkg::swedf_sts_t   sts,
  output swedf_pkg::swedf_cmd_t   cmd
);
  import swedf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EV_RD  = 7'b0000010,
    S_EV_CMP = 7'b0000100,
    S_APPEND = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  // Set once the new event is appended: the eviction pass then leads to the decision.
  logic   pass2_r, pass2_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          pass2_nxt = 1'b0;
          state_nxt = (in_command == CMD_FINISH) ? S_FINISH : S_EV_RD;
        end
      end
      S_EV_RD: begin
        if (sts.occ_zero) begin
          state_nxt = pass2_r ? S_DECIDE : S_APPEND;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EV_CMP;
        end
      end
      S_EV_CMP: begin
        if (!sts.keep) begin
          // Pop the head and fetch the next one in the same cycle.
          cmd.pop     = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          if (sts.occ_one) begin
            state_nxt = pass2_r ? S_DECIDE : S_APPEND;
          end
        end else begin
          cmd.cap_head = 1'b1;
          state_nxt    = pass2_r ? S_DECIDE : S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts.full) begin
          cmd.drop  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.push  = 1'b1;
          pass2_nxt = 1'b1;
          state_nxt = S_EV_RD;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_OUT;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free || !sts.res_pending) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass2_r <= pass2_nxt;
    end
  end

endmodule

// ----- sv/swedf_dp.sv -----
`timescale 1ns / 1ps

module swedf_dp #(
  parameter int QUEUE_DEPTH   = swedf_pkg::DEF_QUEUE_DEPTH,
  parameter int POSITION_BITS = swedf_pkg::DEF_POSITION_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  swedf_pkg::swedf_cmd_t            cmd,
  output swedf_pkg::swedf_sts_t            sts,
  input  logic [POSITION_BITS-1:0]         in_position,
  input  logic [swedf_pkg::LEN_BITS-1:0]   in_ref_length,
  input  logic [swedf_pkg::SIZE_BITS-1:0]  in_event_size,
  input  logic [swedf_pkg::WIN_BITS-1:0]   window_size,
  input  logic [swedf_pkg::SUM_BITS-1:0]   max_sum,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [POSITION_BITS-1:0]         out_span_begin,
  output logic [POSITION_BITS:0]           out_span_end,
  output logic                             out_dropped
);
  import swedf_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_W = POSITION_BITS + LEN_BITS + SIZE_BITS;
  localparam int PB    = POSITION_BITS;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    next_slot = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  logic [MEM_W-1:0] mem [QUEUE_DEPTH];
  logic [MEM_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  logic [PB-1:0]        p_r;
  logic [LEN_BITS-1:0]  l_r;
  logic [SIZE_BITS-1:0] c_r;
  logic [PB-1:0]        head_pos_r;

  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic                  open_r, open_nxt;
  logic [PB-1:0]         open_start_r, open_start_nxt;
  logic [PB:0]           open_end_r, open_end_nxt;

  logic                  res_pending_r, res_pending_nxt;
  logic [PB-1:0]         res_begin_r, res_begin_nxt;
  logic [PB:0]           res_end_r, res_end_nxt;
  logic                  res_drop_r, res_drop_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PB-1:0]         out_begin_r;
  logic [PB:0]           out_end_r;
  logic                  out_drop_r;

  logic [PB-1:0]        rd_pos;
  logic [LEN_BITS-1:0]  rd_len;
  logic [SIZE_BITS-1:0] rd_size;
  logic [PB+1:0]        reach;
  logic [PB+1:0]        p_plus1;
  logic [PB:0]          new_end;
  logic [PB:0]          new_begin;
  logic                 flag;
  logic                 out_free;

  assign rd_pos  = rd_data_r[MEM_W-1 -: PB];
  assign rd_len  = rd_data_r[SIZE_BITS +: LEN_BITS];
  assign rd_size = rd_data_r[SIZE_BITS-1:0];

  // Head stays while its last covered position is inside the window.
  assign reach   = (PB+2)'(rd_pos) + (PB+2)'(rd_len) + (PB+2)'(window_size);
  assign p_plus1 = (PB+2)'(p_r) + (PB+2)'(1);

  assign new_end   = (PB+1)'(p_r) + (PB+1)'(l_r);
  assign new_begin = (PB+1)'(head_pos_r);
  assign flag      = (c_r != '0) && (total_r > TOTAL_BITS'(max_sum)) && (occ_r != '0);
  assign out_free  = !out_valid_r || out_ready;
  assign rd_addr   = cmd.rd_next ? next_slot(head_r) : head_r;

  always_comb begin
    sts.occ_zero    = (occ_r == '0);
    sts.occ_one     = (occ_r == OCC_W'(1));
    sts.full        = (occ_r == OCC_W'(QUEUE_DEPTH));
    sts.keep        = (reach > p_plus1);
    sts.res_pending = res_pending_r;
    sts.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= {p_r, l_r, c_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      p_r <= in_position;
      l_r <= in_ref_length;
      c_r <= in_event_size;
    end
    if (cmd.cap_head) begin
      head_pos_r <= rd_pos;
    end
  end

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    occ_nxt         = occ_r;
    total_nxt       = total_r;
    open_nxt        = open_r;
    open_start_nxt  = open_start_r;
    open_end_nxt    = open_end_r;
    res_pending_nxt = res_pending_r;
    res_begin_nxt   = res_begin_r;
    res_end_nxt     = res_end_r;
    res_drop_nxt    = res_drop_r;

    if (cmd.pop) begin
      head_nxt  = next_slot(head_r);
      occ_nxt   = occ_r - OCC_W'(1);
      total_nxt = total_r - TOTAL_BITS'(rd_size);
    end
    if (cmd.push) begin
      tail_nxt  = next_slot(tail_r);
      occ_nxt   = occ_r + OCC_W'(1);
      total_nxt = total_r + TOTAL_BITS'(c_r);
    end
    if (cmd.drop) begin
      res_pending_nxt = 1'b1;
      res_begin_nxt   = '0;
      res_end_nxt     = '0;
      res_drop_nxt    = 1'b1;
    end
    if (cmd.decide && flag) begin
      if (!open_r) begin
        open_nxt       = 1'b1;
        open_start_nxt = head_pos_r;
        open_end_nxt   = new_end;
      end else if (new_begin <= open_end_r) begin
        if (new_end > open_end_r) begin
          open_end_nxt = new_end;
        end
      end else begin
        // The new span is disjoint: close the open one and start over.
        res_pending_nxt = 1'b1;
        res_begin_nxt   = open_start_r;
        res_end_nxt     = open_end_r;
        res_drop_nxt    = 1'b0;
        open_start_nxt  = head_pos_r;
        open_end_nxt    = new_end;
      end
    end
    if (cmd.finish && open_r) begin
      res_pending_nxt = 1'b1;
      res_begin_nxt   = open_start_r;
      res_end_nxt     = open_end_r;
      res_drop_nxt    = 1'b0;
      open_nxt        = 1'b0;
      open_start_nxt  = '0;
      open_end_nxt    = '0;
    end
    if (cmd.load_out) begin
      res_pending_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out && res_pending_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      occ_r         <= '0;
      total_r       <= '0;
      open_r        <= 1'b0;
      open_start_r  <= '0;
      open_end_r    <= '0;
      res_pending_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      occ_r         <= occ_nxt;
      total_r       <= total_nxt;
      open_r        <= open_nxt;
      open_start_r  <= open_start_nxt;
      open_end_r    <= open_end_nxt;
      res_pending_r <= res_pending_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_begin_r <= res_begin_nxt;
    res_end_r   <= res_end_nxt;
    res_drop_r  <= res_drop_nxt;
    if (cmd.load_out && res_pending_r) begin
      out_begin_r <= res_begin_r;
      out_end_r   <= res_end_r;
      out_drop_r  <= res_drop_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_begin = out_begin_r;
  assign out_span_end   = out_end_r;
  assign out_dropped    = out_drop_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> occ_r != '0)
    else $error("pop from an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> occ_r != OCC_W'(QUEUE_DEPTH))
    else $error("push into a full queue");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && res_pending_r) |-> out_free)
    else $error("result loaded over an untaken transaction");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && occ_r == OCC_W'(1)) |=> total_r == '0)
    else $error("running total not zero with an empty queue");

endmodule
